>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, masked while reset is high
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

// Next-cycle implication that is also checked across reset
`define ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

>>> hw/rtl/sfs_pkg.sv
// Package for the sprite frame sequencer: codes, states, widths, field offsets.
// No dependencies; imported by every module of the block.
package sfs_pkg;

  localparam int MAX_FRAMES  = 256;
  localparam int FRAME_LIMIT = MAX_FRAMES - 1;

  localparam int FRAME_W = 8;
  localparam int PIX_W   = 20;
  localparam int ACC_W   = 17;
  localparam int POS_W   = 9;
  localparam int EL_W    = 16;
  localparam int CFG_W   = 16;
  localparam int CELL_W  = 12;

  // Output tdata layout, lowest bit first
  localparam int OUT_FRAME_LSB = 0;
  localparam int OUT_X_LSB     = OUT_FRAME_LSB + FRAME_W;
  localparam int OUT_Y_LSB     = OUT_X_LSB + PIX_W;
  localparam int OUT_PLAY_BIT  = OUT_Y_LSB + PIX_W;
  localparam int OUT_ADV_BIT   = OUT_PLAY_BIT + 1;
  localparam int OUT_BITS      = OUT_ADV_BIT + 1;
  localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_PAUSE  = 3'd3,
    OP_RESUME = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    REG_FIRST   = 3'd0,
    REG_LAST    = 3'd1,
    REG_REVERSE = 3'd2,
    REG_LOOP    = 3'd3,
    REG_PERIOD  = 3'd4,
    REG_COLUMNS = 3'd5,
    REG_CELL_W  = 3'd6,
    REG_CELL_H  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FRAME,
    S_GRID,
    S_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    G_IDLE,
    G_DIV,
    G_MUL,
    G_DONE
  } grid_state_t;

  // Frame register writes keep the low byte and saturate at the frame limit
  function automatic logic [FRAME_W-1:0] clamp_frame(input logic [CFG_W-1:0] value);
    logic [FRAME_W-1:0] v;
    v = value[FRAME_W-1:0];
    if (int'(v) > FRAME_LIMIT) begin
      return FRAME_W'(FRAME_LIMIT);
    end
    return v;
  endfunction

endpackage

>>> hw/rtl/sfs_grid.sv
// Grid position unit: frame / columns by bit-serial restoring division, then
// remainder * cell_width and quotient * cell_height by bit-serial shift-add.
// Depends on sfs_pkg.
module sfs_grid (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sfs_pkg::FRAME_W-1:0] frame,
  input  logic [sfs_pkg::FRAME_W-1:0] columns,
  input  logic [sfs_pkg::CELL_W-1:0]  cell_w,
  input  logic [sfs_pkg::CELL_W-1:0]  cell_h,
  output logic                       done,
  output logic [sfs_pkg::PIX_W-1:0]   px,
  output logic [sfs_pkg::PIX_W-1:0]   py
);
  import sfs_pkg::*;

  grid_state_t        state, state_next;
  logic [2:0]         cnt;
  logic [FRAME_W-1:0] rem, quo, divisor;
  logic [PIX_W-1:0]   mc_x, mc_y;
  logic [FRAME_W:0]   rem_sh;
  logic               fits;

  // One restoring division step
  assign rem_sh = {rem, quo[FRAME_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      G_IDLE: if (start) state_next = G_DIV;
      G_DIV:  if (cnt == 3'd7) state_next = G_MUL;
      G_MUL:  if (cnt == 3'd7) state_next = G_DONE;
      G_DONE: state_next = G_IDLE;
      default: state_next = G_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done = 1'b0;
    case (state)
      G_DONE:  done = 1'b1;
      default: done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      cnt   <= 3'd0;
    end else begin
      state <= state_next;
      if (state == G_IDLE) begin
        cnt <= 3'd0;
      end else begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  // Shift datapath: quo/rem become the multipliers once division ends
  always_ff @(posedge clk) begin
    case (state)
      G_IDLE: begin
        if (start) begin
          quo     <= frame;
          rem     <= '0;
          divisor <= (columns == '0) ? FRAME_W'(1) : columns;
          mc_x    <= {{(PIX_W-CELL_W){1'b0}}, cell_w};
          mc_y    <= {{(PIX_W-CELL_W){1'b0}}, cell_h};
          px      <= '0;
          py      <= '0;
        end
      end
      G_DIV: begin
        quo <= {quo[FRAME_W-2:0], fits};
        rem <= fits ? FRAME_W'(rem_sh - {1'b0, divisor}) : rem_sh[FRAME_W-1:0];
      end
      G_MUL: begin
        if (rem[0]) px <= px + mc_x;
        if (quo[0]) py <= py + mc_y;
        rem  <= rem >> 1;
        quo  <= quo >> 1;
        mc_x <= mc_x << 1;
        mc_y <= mc_y << 1;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/sprite_frame_sequencer.sv
// Sprite frame sequencer top level: registers, play-list state, handshakes.
// Depends on sfs_pkg and sfs_grid.
//
//  channel   direction  signals                       item
//  s_*       in         tvalid tready tdata tuser     command + elapsed time
//  m_*       out        tvalid tready tdata           frame and pixel position
//  cfg_*     in         we index data                 register write
//
// Each item passes through these steps in order: accept and update the play state,
// pick the frame, the bit-serial division by sheet_columns, the two bit-serial
// multiplies by the cell size, the grid done state, and the output load.
// s_tready is high only while no item is in work; a held output item stalls the
// next item only at its hand-off. Reset (rst, synchronous) restores the state,
// configuration, play and output-valid registers, but not the data registers.
module sprite_frame_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,   // elapsed_us[15:0]
  input  logic [2:0]                     s_tuser,   // opcode[2:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // frame_number[7:0], pixel_x[27:8], pixel_y[47:28], playing[48], advanced[49]
  output logic [sfs_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [sfs_pkg::CFG_W-1:0]      cfg_data
);
  import sfs_pkg::*;

  // Configuration registers
  logic [FRAME_W-1:0] first_frame, last_frame, sheet_columns;
  logic               reverse_enable, loop_enable;
  logic [EL_W-1:0]    frame_period;
  logic [CELL_W-1:0]  cell_width, cell_height;

  // Play state
  logic [ACC_W-1:0]   acc;
  logic [POS_W-1:0]   pos;
  logic               play;

  seq_state_t         state, state_next;
  logic               accept, grid_start, grid_done, out_load;
  logic [FRAME_W-1:0] frame, frame_r;
  logic               adv_r;
  logic [PIX_W-1:0]   grid_x, grid_y;

  // List geometry
  logic               up;
  logic [FRAME_W-1:0] span;
  logic [POS_W-1:0]   len, len_m1;

  assign up     = first_frame <= last_frame;
  assign span   = up ? last_frame - first_frame : first_frame - last_frame;
  assign len_m1 = len - POS_W'(1);

  always_comb begin
    if (span == '0) begin
      len = '0;
    end else if (!reverse_enable) begin
      len = {1'b0, span} + POS_W'(1);
    end else if (loop_enable) begin
      len = {span, 1'b0};
    end else begin
      len = {span, 1'b1};
    end
  end

  // Tick arithmetic
  logic [ACC_W:0]     sum;
  logic [ACC_W-1:0]   acc_sat;
  logic               due;
  logic [POS_W-1:0]   pos_cl, pos_inc;

  assign sum     = {1'b0, acc} + (ACC_W+1)'(s_tdata);
  assign acc_sat = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
  assign due     = acc_sat >= ACC_W'(frame_period);
  assign pos_cl  = (pos >= len) ? len_m1 : pos;
  assign pos_inc = pos_cl + POS_W'(1);

  // Frame at the current (clamped) list position
  logic [POS_W-1:0]   back;
  logic [FRAME_W-1:0] back_cl;

  assign back    = pos_cl - {1'b0, span};
  assign back_cl = (back > {1'b0, span}) ? span : back[FRAME_W-1:0];

  always_comb begin
    if (len == '0) begin
      frame = first_frame;
    end else if (pos_cl <= {1'b0, span}) begin
      frame = up ? first_frame + pos_cl[FRAME_W-1:0] : first_frame - pos_cl[FRAME_W-1:0];
    end else begin
      frame = up ? last_frame - back_cl : last_frame + back_cl;
    end
  end

  // Empty-list check on the values a write leaves behind
  logic [FRAME_W-1:0] first_new, last_new;
  logic               empty_after;

  assign first_new   = (cfg_index == REG_FIRST) ? clamp_frame(cfg_data) : first_frame;
  assign last_new    = (cfg_index == REG_LAST) ? clamp_frame(cfg_data) : last_frame;
  assign empty_after = cfg_we && (cfg_index <= REG_LOOP) && (first_new == last_new);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_FRAME;
      S_FRAME: state_next = S_GRID;
      S_GRID:  if (grid_done) state_next = S_OUT;
      S_OUT:   if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_tready   = 1'b0;
    grid_start = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE:  s_tready = 1'b1;
      S_FRAME: grid_start = 1'b1;
      S_OUT:   out_load = !m_tvalid || m_tready;
      default: begin
      end
    endcase
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_frame    <= '0;
      last_frame     <= '0;
      reverse_enable <= 1'b0;
      loop_enable    <= 1'b0;
      frame_period   <= EL_W'(16667);
      sheet_columns  <= FRAME_W'(1);
      cell_width     <= CELL_W'(1);
      cell_height    <= CELL_W'(1);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_FIRST:   first_frame    <= clamp_frame(cfg_data);
        REG_LAST:    last_frame     <= clamp_frame(cfg_data);
        REG_REVERSE: reverse_enable <= cfg_data[0];
        REG_LOOP:    loop_enable    <= cfg_data[0];
        REG_PERIOD:  frame_period   <= cfg_data[EL_W-1:0];
        REG_COLUMNS: sheet_columns  <= cfg_data[FRAME_W-1:0];
        REG_CELL_W:  cell_width     <= cfg_data[CELL_W-1:0];
        REG_CELL_H:  cell_height    <= cfg_data[CELL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Play state update on each accepted command, and a stop on a write that empties the list
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      pos   <= '0;
      play  <= 1'b0;
      adv_r <= 1'b0;
    end else if (accept) begin
      adv_r <= 1'b0;
      case (op_t'(s_tuser))
        OP_TICK: begin
          if (play && len != '0) begin
            if (due) begin
              acc <= acc_sat - ACC_W'(frame_period);
              if (pos_inc >= len) begin
                if (loop_enable) begin
                  pos   <= '0;
                  adv_r <= 1'b1;
                end else begin
                  pos  <= len_m1;
                  play <= 1'b0;
                end
              end else begin
                pos   <= pos_inc;
                adv_r <= 1'b1;
              end
            end else begin
              acc <= acc_sat;
            end
          end
        end
        OP_START: begin
          pos  <= '0;
          play <= len != '0;
        end
        OP_STOP: begin
          pos  <= '0;
          play <= 1'b0;
        end
        OP_PAUSE:  play <= 1'b0;
        OP_RESUME: play <= len != '0;
        default: begin
        end
      endcase
    end else if (empty_after) begin
      pos  <= '0;
      play <= 1'b0;
    end
  end

  // Frame capture for the result
  always_ff @(posedge clk) begin
    if (grid_start) begin
      frame_r <= frame;
    end
  end

  sfs_grid u_grid (
    .clk     (clk),
    .rst     (rst),
    .start   (grid_start),
    .frame   (frame),
    .columns (sheet_columns),
    .cell_w  (cell_width),
    .cell_h  (cell_height),
    .done    (grid_done),
    .px      (grid_x),
    .py      (grid_y)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(OUT_TDATA_W-OUT_BITS){1'b0}}, adv_r, play, grid_y, grid_x, frame_r};
    end
  end

endmodule

>>> hw/rtl/sfs_checker.sv
// Port-level checker for the sprite frame sequencer, bound to the top level.
// Depends on sfs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [sfs_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import sfs_pkg::*;

  // A stalled result holds
  `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // An advance only happens while still playing
  `ASSERT_IMP(a_adv_playing, m_tvalid && m_tdata[OUT_ADV_BIT], m_tdata[OUT_PLAY_BIT])

  // One item in work at a time
  `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

  // Reset empties the output register
  `ASSERT_NEXT_ALWAYS(a_reset_out, rst, !m_tvalid)

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (.*);

>>> tb/tb_sprite_frame_sequencer.sv
// Self-checking testbench for sprite_frame_sequencer: directed table, then random items.
// Holds its own model of the play list, position and pixel math; needs only sfs_pkg and the RTL.
module tb_sprite_frame_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import sfs_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 467;
  localparam int unsigned ACC_MAX = (1 << ACC_W) - 1;
  // opcodes with no function
  localparam logic [2:0] OP_BAD_LO = 3'd5;
  localparam logic [2:0] OP_BAD_HI = 3'd7;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [PIX_W-1:0]   px;
    logic [PIX_W-1:0]   py;
    logic               playing;
    logic               advanced;
  } frame_out_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  code;  // opcode or register index
    logic [15:0] val;   // elapsed time or register data
    logic        chk;   // typed result below
    frame_out_t  res;
  } row_t;

  localparam frame_out_t ZERO_RES = '0;
  localparam int DIR_N = 42;

  localparam row_t DIR_ROWS [DIR_N] = '{
    // straight out of reset: empty list, nothing plays
    '{ROW_ITEM, OP_START,    16'h0000, 1'b1, ZERO_RES},
    '{ROW_ITEM, OP_TICK,     16'hFFFF, 1'b1, ZERO_RES},
    '{ROW_ITEM, OP_BAD_HI,   16'hFFFF, 1'b1, ZERO_RES},
    // forward run 3..7, large cells
    '{ROW_CFG,  REG_FIRST,   16'hFF03, 1'b0, '0},
    '{ROW_CFG,  REG_LAST,    16'h0007, 1'b0, '0},
    '{ROW_CFG,  REG_PERIOD,  16'd1000, 1'b0, '0},
    '{ROW_CFG,  REG_COLUMNS, 16'h0004, 1'b0, '0},
    '{ROW_CFG,  REG_CELL_W,  16'h0FFF, 1'b0, '0},
    '{ROW_CFG,  REG_CELL_H,  16'hFFFF, 1'b0, '0},
    '{ROW_ITEM, OP_START,    16'h0000, 1'b1, '{8'd3, 20'd12285, 20'd0, 1'b1, 1'b0}},
    '{ROW_ITEM, OP_TICK,     16'd999,  1'b0, '0},
    '{ROW_ITEM, OP_TICK,     16'd1,    1'b0, '0},
    '{ROW_ITEM, OP_TICK,     16'hFFFF, 1'b0, '0},
    '{ROW_ITEM, OP_PAUSE,    16'h0000, 1'b0, '0},
    '{ROW_ITEM, OP_TICK,     16'd5000, 1'b0, '0},
    '{ROW_ITEM, OP_RESUME,   16'h0000, 1'b0, '0},
    '{ROW_ITEM, OP_BAD_LO,   16'h5555, 1'b0, '0},
    '{ROW_ITEM, OP_TICK,     16'd1000, 1'b0, '0},
    '{ROW_ITEM, OP_TICK,     16'd1000, 1'b0, '0},
    // end of list without loop
    '{ROW_ITEM, OP_TICK,     16'd1000, 1'b0, '0},
    // reverse + loop, zero period, zero columns
    '{ROW_CFG,  REG_REVERSE, 16'hFFFF, 1'b0, '0},
    '{ROW_CFG,  REG_LOOP,    16'h0001, 1'b0, '0},
    '{ROW_CFG,  REG_PERIOD,  16'h0000, 1'b0, '0},
    '{ROW_CFG,  REG_COLUMNS, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, OP_RESUME,   16'h0000, 1'b0, '0},
    '{ROW_ITEM, OP_TICK,     16'h0000, 1'b0, '0},
    '{ROW_ITEM, OP_TICK,     16'h0000, 1'b0, '0},
    '{ROW_ITEM, OP_TICK,     16'h0000, 1'b0, '0},
    '{ROW_ITEM, OP_TICK,     16'h0000, 1'b0, '0},
    // first == last forces a stop
    '{ROW_CFG,  REG_LAST,    16'h0000, 1'b0, '0},
    '{ROW_CFG,  REG_FIRST,   16'h0000, 1'b0, '0},
    '{ROW_ITEM, OP_START,    16'h0000, 1'b1, ZERO_RES},
    // widest span, counting down, no loop
    '{ROW_CFG,  REG_FIRST,   16'h00FF, 1'b0, '0},
    '{ROW_CFG,  REG_LOOP,    16'hFFFE, 1'b0, '0},
    '{ROW_CFG,  REG_COLUMNS, 16'h00FF, 1'b0, '0},
    '{ROW_ITEM, OP_START,    16'h0000, 1'b0, '0},
    '{ROW_ITEM, OP_TICK,     16'h0000, 1'b0, '0},
    '{ROW_ITEM, OP_TICK,     16'h0000, 1'b0, '0},
    '{ROW_ITEM, OP_TICK,     16'h0000, 1'b0, '0},
    // shrink the list under the position
    '{ROW_CFG,  REG_LAST,    16'h00FE, 1'b0, '0},
    '{ROW_ITEM, OP_BAD_LO,   16'h0000, 1'b0, '0},
    '{ROW_ITEM, OP_TICK,     16'h0000, 1'b0, '0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [15:0]            s_tdata = '0;
  logic [2:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [2:0]             cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  int unsigned snd_idle_pct = 6;
  int unsigned rcv_idle_pct = 56;
  int          mismatches = 0;
  int          cycles = 0;
  frame_out_t  pending_frames [$];

  // shadow registers and play state
  logic [7:0]  sh_first, sh_last, sh_cols;
  logic        sh_rev, sh_loop;
  logic [15:0] sh_period;
  logic [11:0] sh_cw, sh_ch;
  int unsigned acc, pos;
  logic        play;

  sprite_frame_sequencer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  function automatic int unsigned span_of();
    return (sh_first <= sh_last) ? 32'(sh_last - sh_first) : 32'(sh_first - sh_last);
  endfunction

  function automatic int unsigned play_len();
    int unsigned d;
    d = span_of();
    if (d == 0) return 0;
    if (!sh_rev) return d + 1;
    return sh_loop ? 2 * d : 2 * d + 1;
  endfunction

  // forward run first..last, then back toward first
  function automatic logic [7:0] frame_of_pos(input int unsigned p);
    int unsigned d;
    bit up;
    d = span_of();
    up = (sh_first <= sh_last);
    if (p <= d) return up ? 8'(32'(sh_first) + p) : 8'(32'(sh_first) - p);
    p = p - d;
    if (p > d) p = d;
    return up ? 8'(32'(sh_last) - p) : 8'(32'(sh_last) + p);
  endfunction

  function automatic void cfg_shadow_write(input logic [2:0] idx, input logic [15:0] v);
    case (idx)
      REG_FIRST:   sh_first = (int'(v[7:0]) > FRAME_LIMIT) ? FRAME_W'(FRAME_LIMIT) : v[7:0];
      REG_LAST:    sh_last = (int'(v[7:0]) > FRAME_LIMIT) ? FRAME_W'(FRAME_LIMIT) : v[7:0];
      REG_REVERSE: sh_rev = v[0];
      REG_LOOP:    sh_loop = v[0];
      REG_PERIOD:  sh_period = v;
      REG_COLUMNS: sh_cols = v[7:0];
      REG_CELL_W:  sh_cw = v[11:0];
      REG_CELL_H:  sh_ch = v[11:0];
      default: ;
    endcase
    // an empty list after a list register write acts as a stop
    if (idx <= REG_LOOP && sh_first == sh_last) begin
      play = 1'b0;
      pos = 0;
    end
  endfunction

  function automatic frame_out_t step_sequencer(input logic [2:0] op, input logic [15:0] el);
    frame_out_t r;
    int unsigned len, sum, p, fr, cols;
    r = '0;
    len = play_len();
    case (op)
      OP_TICK: begin
        if (play && len != 0) begin
          sum = acc + 32'(el);
          acc = (sum > ACC_MAX) ? ACC_MAX : sum;
          if (acc >= 32'(sh_period)) begin
            acc = acc - 32'(sh_period);
            p = (pos >= len) ? len - 1 : pos;
            p++;
            if (p >= len) begin
              if (sh_loop) begin
                pos = 0;
                r.advanced = 1'b1;
              end else begin
                pos = len - 1;
                play = 1'b0;
              end
            end else begin
              pos = p;
              r.advanced = 1'b1;
            end
          end
        end
      end
      OP_START: begin
        pos = 0;
        play = (len != 0);
      end
      OP_STOP: begin
        pos = 0;
        play = 1'b0;
      end
      OP_PAUSE: play = 1'b0;
      OP_RESUME: play = (len != 0);
      default: ;
    endcase
    pos = pos & 32'h1FF;
    if (len == 0) fr = 32'(sh_first);
    else fr = 32'(frame_of_pos((pos >= len) ? len - 1 : pos));
    cols = (sh_cols == 0) ? 1 : 32'(sh_cols);
    r.frame = fr[7:0];
    r.px = PIX_W'((fr % cols) * 32'(sh_cw));
    r.py = PIX_W'((fr / cols) * 32'(sh_ch));
    r.playing = play;
    return r;
  endfunction

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    frame_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_frames.size() == 0) begin
        $error("result with no expectation waiting: tdata %h", m_tdata);
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        if (m_tdata[OUT_FRAME_LSB +: FRAME_W] !== want.frame) begin
          $error("frame_number: expected %0d, got %0d", want.frame,
                 m_tdata[OUT_FRAME_LSB +: FRAME_W]);
          mismatches++;
        end
        if (m_tdata[OUT_X_LSB +: PIX_W] !== want.px) begin
          $error("pixel_x: expected %0d, got %0d", want.px, m_tdata[OUT_X_LSB +: PIX_W]);
          mismatches++;
        end
        if (m_tdata[OUT_Y_LSB +: PIX_W] !== want.py) begin
          $error("pixel_y: expected %0d, got %0d", want.py, m_tdata[OUT_Y_LSB +: PIX_W]);
          mismatches++;
        end
        if (m_tdata[OUT_PLAY_BIT] !== want.playing) begin
          $error("playing: expected %0d, got %0d", want.playing, m_tdata[OUT_PLAY_BIT]);
          mismatches++;
        end
        if (m_tdata[OUT_ADV_BIT] !== want.advanced) begin
          $error("advanced: expected %0d, got %0d", want.advanced, m_tdata[OUT_ADV_BIT]);
          mismatches++;
        end
      end
    end
  end

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic send_item(input logic [2:0] op, input logic [15:0] el,
                           input logic typed, input frame_out_t typed_res);
    frame_out_t got;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= el;
    do @(posedge clk); while (!s_tready);
    got = step_sequencer(op, el);
    pending_frames.insert(pending_frames.size(), typed ? typed_res : got);
    @(negedge clk);
  endtask

  // hold the sender until every result is back and the block has gone quiet
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    cfg_shadow_write(idx, v);
    @(negedge clk);
  endtask

  // random register set; short spans and small periods dominate
  task automatic random_setup(input bit all_regs);
    int off, lf;
    logic [15:0] hi;
    drain_results();
    hi = 16'($urandom);
    if (all_regs || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 5))
        0: write_reg(REG_FIRST, {hi[15:8], 8'h00});
        1: write_reg(REG_FIRST, {hi[15:8], 8'hFF});
        default: write_reg(REG_FIRST, {hi[15:8], 8'($urandom)});
      endcase
    end
    if (all_regs || $urandom_range(0, 3) != 0) begin
      off = $urandom_range(0, 12) - 6;
      case ($urandom_range(0, 7))
        0: lf = int'($urandom_range(0, 255));
        1: lf = (sh_first < 128) ? 255 : 0;
        default: lf = int'(sh_first) + off;
      endcase
      if (lf < 0) lf = 0;
      if (lf > 255) lf = 255;
      write_reg(REG_LAST, {hi[7:0], 8'(lf)});
    end
    if (all_regs || $urandom_range(0, 1)) write_reg(REG_REVERSE, 16'($urandom));
    if (all_regs || $urandom_range(0, 1)) write_reg(REG_LOOP, 16'($urandom));
    if (all_regs || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 9))
        0: write_reg(REG_PERIOD, 16'h0000);
        1: write_reg(REG_PERIOD, 16'h0001);
        2: write_reg(REG_PERIOD, 16'hFFFF);
        3: write_reg(REG_PERIOD, 16'($urandom_range(1, 65535)));
        default: write_reg(REG_PERIOD, 16'($urandom_range(1, 300)));
      endcase
    end
    if (all_regs || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 5))
        0: write_reg(REG_COLUMNS, {hi[15:8], 8'h00});
        1: write_reg(REG_COLUMNS, {hi[15:8], 8'h01});
        2: write_reg(REG_COLUMNS, {hi[15:8], 8'hFF});
        default: write_reg(REG_COLUMNS, {hi[15:8], 8'($urandom_range(1, 16))});
      endcase
    end
    if (all_regs || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 4))
        0: write_reg(REG_CELL_W, {hi[15:12], 12'h000});
        1: write_reg(REG_CELL_W, {hi[15:12], 12'hFFF});
        default: write_reg(REG_CELL_W, 16'($urandom));
      endcase
    end
    if (all_regs || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 4))
        0: write_reg(REG_CELL_H, {hi[11:8], 12'h001});
        1: write_reg(REG_CELL_H, {hi[11:8], 12'hFFF});
        default: write_reg(REG_CELL_H, 16'($urandom));
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase, issued, burst, k, r;
    int unsigned el_cap;
    logic [2:0] op;
    logic [15:0] el;
    bit in_cfg;

    // reset values of the shadow state
    sh_first = '0;
    sh_last = '0;
    sh_rev = 1'b0;
    sh_loop = 1'b0;
    sh_period = 16'd16667;
    sh_cols = 8'd1;
    sh_cw = 12'd1;
    sh_ch = 12'd1;
    acc = 0;
    pos = 0;
    play = 1'b0;
    in_cfg = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    for (k = 0; k < DIR_N; k++) begin
      if (DIR_ROWS[k].kind == ROW_CFG) begin
        if (!in_cfg) drain_results();
        write_reg(DIR_ROWS[k].code, DIR_ROWS[k].val);
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) cfg_we <= 1'b0;
        in_cfg = 1'b0;
        send_item(DIR_ROWS[k].code, DIR_ROWS[k].val, DIR_ROWS[k].chk, DIR_ROWS[k].res);
      end
    end

    // random phases: sender mostly busy, then receiver mostly busy, then no idling
    for (phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 56 : 0;
      rcv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 6 : 0;
      random_setup(1'b1);
      issued = 0;
      while (issued < PHASE_ITEMS) begin
        burst = $urandom_range(30, 70);
        for (k = 0; k < burst && issued < PHASE_ITEMS; k++) begin
          r = $urandom_range(0, 99);
          if (r < 68) op = OP_TICK;
          else if (r < 76) op = OP_START;
          else if (r < 80) op = OP_STOP;
          else if (r < 86) op = OP_PAUSE;
          else if (r < 94) op = OP_RESUME;
          else op = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
          el_cap = 2 * 32'(sh_period) + 1;
          if (el_cap > 65535) el_cap = 65535;
          case ($urandom_range(0, 9))
            0: el = 16'h0000;
            1: el = 16'hFFFF;
            2, 3: el = 16'($urandom);
            default: el = 16'($urandom_range(0, el_cap));
          endcase
          send_item(op, el, 1'b0, '0);
          issued++;
        end
        if (issued < PHASE_ITEMS) random_setup(1'b0);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
